// ----- design/sqwt_pkg.sv -----
`timescale 1ns / 1ps
package sqwt_pkg;

  localparam int DEF_CAPACITY    = 16;
  localparam int DEF_THREAD_BITS = 8;

  localparam int TICK_W      = 32;
  localparam int DELAY_W     = 16;
  localparam int THREAD_ID_W = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  localparam logic ACT_SLEEP = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_WOKEN    = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic sleep;
    logic tick;
    logic rd;
    logic keep;
    logic hold;
    logic swap;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_done;
    logic woke;
    logic pend;
  } status_t;

endpackage

// ----- design/sqwt_ram.sv -----
`timescale 1ns / 1ps
module sqwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/sqwt_ctrl.sv -----
`timescale 1ns / 1ps
module sqwt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            action,
  input  sqwt_pkg::status_t st,
  output logic            in_tready,
  output sqwt_pkg::cmd_t  cmd
);
  import sqwt_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   idle_ready;

  assign idle_ready = (state_r == ST_IDLE) && st.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && idle_ready && (action == ACT_TICK)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = st.scan_done ? ST_DONE : ST_EVAL;
      end
      ST_EVAL: begin
        if (!st.woke || !st.pend || st.out_free) begin
          state_nxt = ST_READ;
        end
      end
      ST_DONE: begin
        if (st.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = idle_ready;
        if (in_tvalid && idle_ready) begin
          cmd.sleep = (action == ACT_SLEEP);
          cmd.tick  = (action == ACT_TICK);
        end
      end
      ST_READ: begin
        cmd.rd = !st.scan_done;
      end
      ST_EVAL: begin
        cmd.keep = !st.woke;
        cmd.hold = st.woke && !st.pend;
        cmd.swap = st.woke && st.pend && st.out_free;
      end
      ST_DONE: begin
        cmd.fin = st.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- design/sqwt_datapath.sv -----
`timescale 1ns / 1ps
module sqwt_datapath #(
  parameter int CAPACITY    = sqwt_pkg::DEF_CAPACITY,
  parameter int THREAD_BITS = sqwt_pkg::DEF_THREAD_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sqwt_pkg::cmd_t                   cmd,
  output sqwt_pkg::status_t                st,
  input  logic [sqwt_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sqwt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast
);
  import sqwt_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = THREAD_BITS + TICK_W;

  logic [TICK_W-1:0]      tick_r;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          rd_idx_r;
  logic [CW-1:0]          wr_idx_r;
  logic [CW-1:0]          woken_r;
  logic                   pend_r;
  logic [THREAD_BITS-1:0] pend_thr_r;

  logic                   out_valid_r;
  kind_t                  out_kind_r;
  logic [THREAD_ID_W-1:0] out_thr_r;
  logic                   out_last_r;
  logic                   out_empty_r;

  logic [THREAD_ID_W-1:0] in_thread;
  logic [DELAY_W-1:0]     in_delay;
  logic                   full;
  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [RW-1:0]          ram_wdata;
  logic [RW-1:0]          ram_rdata;
  logic [THREAD_BITS-1:0] rd_thread;
  logic [TICK_W-1:0]      rd_deadline;
  logic [TICK_W-1:0]      diff;
  logic                   pend_empty;

  assign in_thread   = in_tdata[8:1];
  assign in_delay    = in_tdata[24:9];
  assign full        = (count_r == CW'(CAPACITY));
  assign rd_thread   = ram_rdata[THREAD_BITS-1:0];
  assign rd_deadline = ram_rdata[RW-1:THREAD_BITS];
  assign diff        = tick_r - rd_deadline;
  assign pend_empty  = (count_r == woken_r + CW'(1));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_idx_r[IW-1:0];
    ram_wdata = ram_rdata;
    if (cmd.sleep && !full) begin
      ram_we    = 1'b1;
      ram_waddr = count_r[IW-1:0];
      ram_wdata = {tick_r + TICK_W'(in_delay), THREAD_BITS'(in_thread)};
    end else if (cmd.keep) begin
      ram_we = 1'b1;
    end
  end

  sqwt_ram #(
    .WIDTH(RW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd),
    .raddr(rd_idx_r[IW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      if (cmd.sleep && !full) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.tick) begin
        tick_r <= tick_r + TICK_W'(1);
        pend_r <= 1'b0;
      end
      if (cmd.hold) begin
        pend_r <= 1'b1;
      end
      if (cmd.fin) begin
        count_r <= wr_idx_r;
        pend_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      rd_idx_r <= '0;
      wr_idx_r <= '0;
      woken_r  <= '0;
    end
    if (cmd.keep) begin
      wr_idx_r <= wr_idx_r + CW'(1);
      rd_idx_r <= rd_idx_r + CW'(1);
    end
    if (cmd.hold) begin
      pend_thr_r <= rd_thread;
      rd_idx_r   <= rd_idx_r + CW'(1);
    end
    if (cmd.swap) begin
      pend_thr_r <= rd_thread;
      woken_r    <= woken_r + CW'(1);
      rd_idx_r   <= rd_idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.sleep || cmd.swap || cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sleep) begin
      out_kind_r  <= full ? KIND_REJECTED : KIND_ACCEPTED;
      out_thr_r   <= '0;
      out_last_r  <= 1'b1;
      out_empty_r <= full && (count_r == '0);
    end else if (cmd.swap) begin
      out_kind_r  <= KIND_WOKEN;
      out_thr_r   <= THREAD_ID_W'(pend_thr_r);
      out_last_r  <= 1'b0;
      out_empty_r <= pend_empty;
    end else if (cmd.fin) begin
      out_last_r <= 1'b1;
      if (pend_r) begin
        out_kind_r  <= KIND_WOKEN;
        out_thr_r   <= THREAD_ID_W'(pend_thr_r);
        out_empty_r <= pend_empty;
      end else begin
        out_kind_r  <= KIND_NONE;
        out_thr_r   <= '0;
        out_empty_r <= (wr_idx_r == '0);
      end
    end
  end

  assign st.out_free  = !out_valid_r || out_tready;
  assign st.scan_done = (rd_idx_r == count_r);
  assign st.woke      = !diff[TICK_W-1];
  assign st.pend      = pend_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - THREAD_ID_W - 1){1'b0}}, out_empty_r, out_thr_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- design/sleep_queue_wakeup_timer.sv -----
`timescale 1ns / 1ps
// Timed sleep queue. A sleep beat stores a thread with deadline tick + delay in a list of
// up to CAPACITY sleepers and answers with one accepted or rejected beat in the cycle after
// it is taken. A tick beat advances the 32-bit counter, then walks the list in insertion
// order, waking every sleeper whose deadline has been reached (wrap-safe signed compare)
// and compacting the rest; it emits one woken beat per sleeper, tlast on the final one, or
// a single none-woken beat. A tick walks the list with a read-then-evaluate loop over the
// single-read-port sleeper RAM, and output back-pressure can stall that walk. Only one beat
// is worked on at a time.
module sleep_queue_wakeup_timer #(
  parameter int CAPACITY    = sqwt_pkg::DEF_CAPACITY,
  parameter int THREAD_BITS = sqwt_pkg::DEF_THREAD_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [0] action, [8:1] thread_id, [24:9] delay, [31:25] zero
  input  logic [sqwt_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] woken_thread, [8] queue_empty, [15:9] zero
  output logic [sqwt_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [1:0] kind
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast
);
  import sqwt_pkg::*;

  cmd_t    cmd;
  status_t st;

  sqwt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .action   (in_tdata[0]),
    .st       (st),
    .in_tready(in_tready),
    .cmd      (cmd)
  );

  sqwt_datapath #(
    .CAPACITY   (CAPACITY),
    .THREAD_BITS(THREAD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import sqwt_pkg::*;

  localparam int LIMIT = 1500000;
  localparam int SEGMENTS = 8;
  localparam int SEG_ITEMS = 40;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] thr;
    logic       last;
    logic       empty;
  } wake_beat_t;

  class sleep_scoreboard;
    bit [31:0]  ticks;
    bit [7:0]   sleeper_thr[$];
    bit [31:0]  sleeper_due[$];
    wake_beat_t awaited[$];
    int         errors;
    int         n_accepted;
    int         n_rejected;
    int         n_woken;
    int         n_none;

    function int outstanding();
      return awaited.size();
    endfunction

    function void note_input(bit act, bit [7:0] tid, bit [15:0] dly);
      wake_beat_t b;
      bit [31:0]  diff;
      bit [7:0]   tmask;
      int         i;
      int         first;
      tmask = 8'((1 << DEF_THREAD_BITS) - 1);
      if (act == ACT_SLEEP) begin
        if (sleeper_thr.size() >= DEF_CAPACITY) begin
          b = '{KIND_REJECTED, 8'd0, 1'b1, sleeper_thr.size() == 0};
          n_rejected++;
        end else begin
          sleeper_thr = {sleeper_thr, tid & tmask};
          sleeper_due = {sleeper_due, ticks + 32'(dly)};
          b = '{KIND_ACCEPTED, 8'd0, 1'b1, 1'b0};
          n_accepted++;
        end
        awaited = {awaited, b};
        return;
      end
      ticks = ticks + 1;
      first = awaited.size();
      i = 0;
      while (i < sleeper_thr.size()) begin
        diff = ticks - sleeper_due[i];
        if (!diff[31]) begin
          b = '{KIND_WOKEN, sleeper_thr[i], 1'b0, sleeper_thr.size() == 1};
          sleeper_thr.delete(i);
          sleeper_due.delete(i);
          awaited = {awaited, b};
          n_woken++;
        end else begin
          i++;
        end
      end
      if (awaited.size() == first) begin
        b = '{KIND_NONE, 8'd0, 1'b1, sleeper_thr.size() == 0};
        awaited = {awaited, b};
        n_none++;
      end else begin
        awaited[awaited.size() - 1].last = 1'b1;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [1:0] kind, logic [7:0] thr, logic last, logic empty);
      wake_beat_t e;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected beat kind=%0d thr=%0d", kind, thr));
        return;
      end
      e = awaited.pop_front();
      if (kind !== e.kind)
        report($sformatf("kind %0d, want %0d", kind, e.kind));
      if (thr !== e.thr)
        report($sformatf("woken_thread %0d, want %0d", thr, e.thr));
      if (last !== e.last)
        report($sformatf("last %0b, want %0b", last, e.last));
      if (empty !== e.empty)
        report($sformatf("queue_empty %0b, want %0b", empty, e.empty));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;

  sleep_scoreboard sb = new();
  int  cycles = 0;
  int  items_sent = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;

  sleep_queue_wakeup_timer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, sb.outstanding());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function int pick_gap();
    if ($urandom_range(0, 99) < 85)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left == 0 && !calm && $urandom_range(0, 99) < 20)
      stall_left = pick_gap();
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // sample a half period ahead of the edge that takes the beat
  always @(negedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      sb.check_result(out_tuser, out_tdata[7:0], out_tlast, out_tdata[8]);
  end

  task idle_gap();
    if (!calm && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task send_beat(bit act, bit [7:0] tid, bit [15:0] dly);
    bit hs;
    idle_gap();
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, dly, tid, act};
    do begin
      @(negedge clk);
      hs = in_tready === 1'b1;
      @(posedge clk);
    end while (!hs);
    sb.note_input(act, tid, dly);
    items_sent++;
  endtask

  task drain();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task send_random(int sleep_pct);
    bit [15:0] dly;
    int        r;
    r = $urandom_range(0, 99);
    if (r < 80)
      dly = 16'($urandom_range(0, 7));
    else if (r < 99)
      dly = 16'($urandom_range(0, 63));
    else
      dly = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 99) < sleep_pct)
      send_beat(ACT_SLEEP, 8'($urandom_range(0, 255)), dly);
    else
      send_beat(ACT_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    int seg;
    int k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // tick on an empty list, then a zero-delay sleeper woken on the next tick
    send_beat(ACT_TICK, 8'hFF, 16'hFFFF);
    send_beat(ACT_SLEEP, 8'h00, 16'h0000);
    send_beat(ACT_TICK, 8'h00, 16'h0000);
    // a sleeper that never wakes, then a tick waking two of three
    send_beat(ACT_SLEEP, 8'hFF, 16'hFFFF);
    send_beat(ACT_SLEEP, 8'hAA, 16'h0001);
    send_beat(ACT_SLEEP, 8'h55, 16'h0002);
    send_beat(ACT_SLEEP, 8'h01, 16'h0001);
    send_beat(ACT_TICK, 8'h12, 16'h3456);
    // fill the list past capacity, then wake nearly all of it at once
    for (k = 0; k < 15; k++)
      send_beat(ACT_SLEEP, 8'(k * 17), 16'(k % 2));
    send_beat(ACT_TICK, 8'h00, 16'h0000);
    send_beat(ACT_TICK, 8'h00, 16'h0000);
    drain();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      calm = $urandom_range(0, 3) == 0;
      case ($urandom_range(0, 2))
        0: for (k = 0; k < SEG_ITEMS; k++) send_random(25);
        1: for (k = 0; k < SEG_ITEMS; k++) send_random(50);
        default: for (k = 0; k < SEG_ITEMS; k++) send_random(75);
      endcase
      if (seg == SEGMENTS / 2)
        drain();
    end
    calm = 1'b0;

    drain();
    repeat (50) @(posedge clk);

    $display("%0d beats in: %0d accepted, %0d rejected, %0d ticks with nobody woken",
             items_sent, sb.n_accepted, sb.n_rejected, sb.n_none);
    $display("%0d threads woken, final tick count %0d, %0d still asleep",
             sb.n_woken, sb.ticks, sb.sleeper_thr.size());
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
